// ===== src/rfbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame block cache package
// Shared types, widths, status and action codes for the frame block cache.
// ----------------------------------------------------------------------------
package rfbc_pkg;

    localparam int BLOCKS_DEF  = 64;
    localparam int ENTRIES_DEF = 64;

    localparam logic [1:0] ACT_LOCK   = 2'd0;
    localparam logic [1:0] ACT_UNLOCK = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE   = 2'd2;
    localparam logic [1:0] ST_OVER_LIMIT = 2'd3;

    localparam logic CFG_BLOCK_SIZE = 1'b0;
    localparam logic CFG_BASE_ADDR  = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [30:0] serial;
        logic [30:0] newest_serial;
        logic        frame_present;
        logic [23:0] frame_size;
        logic [7:0]  frame_type;
        logic [23:0] buffer_limit;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [32:0] entry_address;
        logic [23:0] stored_size;
        logic [7:0]  stored_type;
        logic [15:0] lock_count;
        logic [5:0]  first_block;
        logic [6:0]  block_count;
    } t_out_word;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic run_step;
        logic mem_rd;
        logic commit_lock;
        logic bump_lock;
        logic dec_lock;
        logic free_step;
        logic mul_step;
        logic fail_nf;
        logic fail_ns;
        logic fail_ol;
        logic emit;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;
        logic hit;
        logic has_empty;
        logic div_done;
        logic run_done;
        logic run_found;
        logic free_done;
        logic mul_done;
        logic locks_zero;
        logic over_limit;
    } t_sts;

endpackage

// ===== src/rfbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame block cache controller
// Sequences scan, divide, run search, table read, update, block free and address multiply per word.
// ----------------------------------------------------------------------------
module rfbc_ctrl
    import rfbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_in_word i_in_word,
    input  t_sts     i_sts,
    output t_cmd     o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_DIV = 4'd3;
    localparam logic [3:0] S_RUN = 4'd4;
    localparam logic [3:0] S_RD = 4'd5;
    localparam logic [3:0] S_UPD = 4'd6;
    localparam logic [3:0] S_FREE = 4'd7;
    localparam logic [3:0] S_MUL = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;
    localparam logic [3:0] S_RD2 = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [1:0] r_act;
    logic       r_present;
    logic       r_ovalid;
    logic       n_ovalid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_out_stall;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_act == ACT_LOCK) begin
                    if (i_sts.hit) begin
                        o_cmd.mem_rd = 1'b1;
                        n_state      = S_RD;
                    end else if (!r_present) begin
                        o_cmd.fail_nf = 1'b1;
                        n_state       = S_OUT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else if ((r_act == ACT_UNLOCK || r_act == ACT_READ) && i_sts.hit) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_RD;
                end else begin
                    o_cmd.fail_nf = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.run_step = 1'b1;
                if (i_sts.run_done) begin
                    if (i_sts.run_found && i_sts.has_empty) begin
                        o_cmd.commit_lock = 1'b1;
                        n_state           = S_MUL;
                    end else begin
                        o_cmd.fail_ns = 1'b1;
                        n_state       = S_OUT;
                    end
                end
            end
            S_RD: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                if (r_act == ACT_LOCK) begin
                    o_cmd.bump_lock = 1'b1;
                    n_state         = S_MUL;
                end else if (r_act == ACT_UNLOCK) begin
                    o_cmd.dec_lock = 1'b1;
                    n_state        = S_UPD;
                end else if (i_sts.over_limit) begin
                    o_cmd.fail_ol = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_UPD: begin
                n_state = i_sts.locks_zero ? S_FREE : S_MUL;
            end
            S_FREE: begin
                o_cmd.free_step = 1'b1;
                if (i_sts.free_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.emit = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        if (o_cmd.load) begin
            r_act     <= i_in_word.action;
            r_present <= i_in_word.frame_present;
        end
    end

endmodule

// ===== src/rfbc_dp.sv =====
// ----------------------------------------------------------------------------
// Frame block cache datapath
// Entry tables, free-block map, serial divider, run search and address multiply.
// ----------------------------------------------------------------------------
module rfbc_dp
    import rfbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  t_in_word    i_in_word,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output t_out_word   o_out_word
);

    localparam int BLOCKS  = BLOCKS_DEF;
    localparam int ENTRIES = ENTRIES_DEF;
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CW = $clog2(BLOCKS + 1);
    localparam int RESW = $bits(t_out_word) - 2;

    logic [20:0] r_bsize;
    logic [31:0] r_base;
    logic [20:0] w_bs;

    logic [ENTRIES-1:0] r_valid;
    logic [BLOCKS-1:0]  r_free;

    logic [30:0] r_mserial [ENTRIES];
    logic [5:0]  r_mfirst  [ENTRIES];
    logic [6:0]  r_mcount  [ENTRIES];
    logic [23:0] r_msize   [ENTRIES];
    logic [7:0]  r_mtype   [ENTRIES];
    logic [15:0] r_mlocks  [ENTRIES];

    t_in_word    r_in;
    logic [EW:0] r_scan;
    logic [30:0] r_ser_q;
    logic [EW-1:0] r_cmp_idx;
    logic        r_cmp_vld;
    logic        r_hit;
    logic [EW-1:0] r_hit_idx;
    logic        r_has_empty;
    logic [EW-1:0] r_empty_idx;

    logic [23:0] r_quo;
    logic [20:0] r_rem;
    logic [4:0]  r_dcnt;
    logic        r_div_done;
    logic [21:0] w_trial;

    logic [BW:0] r_rpos;
    logic [CW:0] r_run;
    logic        r_run_done;
    logic        r_found;
    logic [BW-1:0] r_first_blk;
    logic [24:0] r_need;

    logic [EW-1:0] r_sel;
    logic [5:0]  r_first;
    logic [6:0]  r_count;
    logic [23:0] r_size;
    logic [7:0]  r_type;
    logic [15:0] r_locks;

    logic [7:0]  r_fidx;
    logic [1:0]  r_mcyc;
    logic [32:0] r_addr;
    t_out_word   r_res;
    t_out_word   r_out;

    assign w_bs = (r_bsize == '0) ? 21'd1 : r_bsize;
    assign w_trial = {r_rem, r_quo[23]} - {1'b0, w_bs};

    assign o_sts.scan_done  = r_scan[EW] && !r_cmp_vld;
    assign o_sts.hit        = r_hit && (r_in.serial <= r_in.newest_serial);
    assign o_sts.has_empty  = r_has_empty;
    assign o_sts.div_done   = r_div_done;
    assign o_sts.run_done   = r_run_done;
    assign o_sts.run_found  = r_found;
    assign o_sts.free_done  = (r_fidx >= {1'b0, r_count});
    assign o_sts.mul_done   = (r_mcyc == 2'd2);
    assign o_sts.locks_zero = (r_locks == 16'd0);
    assign o_sts.over_limit = (r_size > r_in.buffer_limit);
    assign o_out_word = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsize <= 21'd4096;
            r_base  <= '0;
            r_valid <= '0;
            r_free  <= '1;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_BLOCK_SIZE) begin
                r_bsize <= i_cfg_data[20:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_BASE_ADDR) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.run_step && r_run_done && r_found && r_has_empty) begin
                r_valid[r_empty_idx] <= 1'b1;
            end
            if (i_cmd.commit_lock) begin
                for (int b = 0; b < BLOCKS; b++) begin
                    if (b >= int'(r_first_blk) && b < int'(r_first_blk) + int'(r_need)) begin
                        r_free[b] <= 1'b0;
                    end
                end
            end
            if (i_cmd.free_step) begin
                r_valid[r_sel] <= 1'b0;
            end
            if (i_cmd.free_step && !o_sts.free_done) begin
                if ({2'b0, r_first} + {1'b0, r_fidx} < 9'(BLOCKS)) begin
                    r_free[BW'({2'b0, r_first} + {1'b0, r_fidx})] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in        <= i_in_word;
            r_scan      <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_has_empty <= 1'b0;
            r_hit_idx   <= '0;
            r_empty_idx <= '0;
        end
        if (i_cmd.scan_step) begin
            r_cmp_vld <= !r_scan[EW];
            if (!r_scan[EW]) begin
                r_ser_q   <= r_mserial[r_scan[EW-1:0]];
                r_cmp_idx <= r_scan[EW-1:0];
                r_scan    <= (r_scan[EW-1:0] == EW'(ENTRIES-1)) ? {1'b1, {EW{1'b0}}}
                                                                 : r_scan + 1'b1;
            end
            if (r_cmp_vld) begin
                if (r_valid[r_cmp_idx] && !r_hit && r_ser_q == r_in.serial) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                end
                if (!r_valid[r_cmp_idx] && !r_has_empty) begin
                    r_has_empty <= 1'b1;
                    r_empty_idx <= r_cmp_idx;
                end
            end
        end

        if (i_cmd.div_start) begin
            r_quo      <= r_in.frame_size;
            r_rem      <= '0;
            r_dcnt     <= '0;
            r_div_done <= 1'b0;
            r_rpos     <= '0;
            r_run      <= '0;
            r_run_done <= 1'b0;
            r_found    <= 1'b0;
            r_first_blk <= '0;
        end
        if (i_cmd.div_step && !r_div_done) begin
            if (!w_trial[21]) begin
                r_rem <= w_trial[20:0];
                r_quo <= {r_quo[22:0], 1'b1};
            end else begin
                r_rem <= {r_rem[19:0], r_quo[23]};
                r_quo <= {r_quo[22:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 1'b1;
            if (r_dcnt == 5'd23) begin
                r_div_done <= 1'b1;
            end
        end
        if (i_cmd.div_step && r_div_done) begin
            r_need <= {1'b0, r_quo} + ((r_rem != '0) ? 25'd1 : 25'd0);
        end

        if (i_cmd.run_step && !r_run_done) begin
            if (r_need == '0) begin
                r_found     <= 1'b1;
                r_first_blk <= '0;
                r_run_done  <= 1'b1;
            end else if (r_need > 25'(BLOCKS) || r_rpos == (BW+1)'(BLOCKS)) begin
                r_run_done <= 1'b1;
            end else if (r_free[r_rpos[BW-1:0]]) begin
                if (25'(r_run) + 25'd1 >= r_need) begin
                    r_found     <= 1'b1;
                    r_run_done  <= 1'b1;
                    r_first_blk <= BW'(25'(r_rpos) + 25'd1 - r_need);
                end
                r_run  <= r_run + 1'b1;
                r_rpos <= r_rpos + 1'b1;
            end else begin
                r_run  <= '0;
                r_rpos <= r_rpos + 1'b1;
            end
        end

        if (i_cmd.commit_lock) begin
            r_mserial[r_empty_idx] <= r_in.serial;
            r_mfirst[r_empty_idx]  <= 6'(r_first_blk);
            r_mcount[r_empty_idx]  <= 7'(r_need);
            r_msize[r_empty_idx]   <= r_in.frame_size;
            r_mtype[r_empty_idx]   <= r_in.frame_type;
            r_mlocks[r_empty_idx]  <= 16'd1;
            r_sel   <= r_empty_idx;
            r_first <= 6'(r_first_blk);
            r_count <= 7'(r_need);
            r_size  <= r_in.frame_size;
            r_type  <= r_in.frame_type;
            r_locks <= 16'd1;
            r_mcyc  <= '0;
        end
        if (i_cmd.mem_rd) begin
            r_sel   <= r_hit_idx;
            r_first <= r_mfirst[r_hit_idx];
            r_count <= r_mcount[r_hit_idx];
            r_size  <= r_msize[r_hit_idx];
            r_type  <= r_mtype[r_hit_idx];
            r_locks <= r_mlocks[r_hit_idx];
            r_mcyc  <= '0;
            r_fidx  <= '0;
        end
        if (i_cmd.bump_lock && r_locks != 16'hFFFF) begin
            r_locks <= r_locks + 1'b1;
            r_mlocks[r_sel] <= r_locks + 1'b1;
        end
        if (i_cmd.dec_lock && r_locks != 16'd0) begin
            r_locks <= r_locks - 1'b1;
            r_mlocks[r_sel] <= r_locks - 1'b1;
        end
        if (i_cmd.free_step && !o_sts.free_done) begin
            r_fidx <= r_fidx + 1'b1;
        end
        if (i_cmd.mul_step) begin
            if (r_mcyc == 2'd0) begin
                r_addr <= 33'(27'(r_first) * 27'(w_bs));
            end else if (r_mcyc == 2'd1) begin
                r_addr <= r_addr + {1'b0, r_base};
            end
            if (r_mcyc != 2'd2) begin
                r_mcyc <= r_mcyc + 1'b1;
            end
        end

        if (i_cmd.fail_nf) begin
            r_res <= {ST_NOT_FOUND, {RESW{1'b0}}};
        end else if (i_cmd.fail_ns) begin
            r_res <= {ST_NO_SPACE, {RESW{1'b0}}};
        end else if (i_cmd.fail_ol) begin
            r_res <= {ST_OVER_LIMIT, {RESW{1'b0}}};
        end else if (i_cmd.mul_step && r_mcyc == 2'd2) begin
            r_res <= {ST_OK, r_addr, r_size, r_type, r_locks, r_first, r_count};
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

endmodule

// ===== src/refcounted_frame_block_cache_core.sv =====
// ----------------------------------------------------------------------------
// Frame block cache core
// Reference-counted cache of frames placed in contiguous fixed-size blocks.
// ----------------------------------------------------------------------------
// Input words arrive on i_in_valid / o_in_stall and carry one lock, unlock or
// read request. Each word gives exactly one result word on o_out_valid /
// i_out_stall. One word is handled at a time. A request first reads all
// ENTRIES table entries one per cycle, and its result follows the scan. A
// read or a lock of a cached serial then reads the entry, a lock raises its
// lock count, and both form the address by a multiply; a read ends early
// when it reports over_limit. An unlock lowers the lock count and, when the
// count is then zero, frees the entry and then its blocks one by one. A lock
// that places a new frame adds a divider and a free-block search before the
// multiply. The next word is accepted in the cycle after a result is loaded.
// A synchronous active-low reset empties every entry, frees every block and
// sets block_size to 4096 and base_address to zero. The result register
// holds its word while the receiver stalls; the next input word may be
// accepted meanwhile, but its result waits until the register is taken.
// Configuration writes are taken at any time and must be made while idle.
// ----------------------------------------------------------------------------
module refcounted_frame_block_cache_core
    import rfbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    t_cmd w_cmd;
    t_sts w_sts;

    rfbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_in_word   (i_in_word),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rfbc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_word  (i_in_word),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_word (o_out_word)
    );

endmodule
